### rtl/gpa_pkg.sv
// Package for the gravity pair acceleration accumulator.
// Field widths, fixed-point constants and the saturating helpers.
// No dependencies.
package gpa_pkg;

    localparam int FIELD_BITS      = 32;
    localparam int MASS_BITS       = 32;
    localparam int ACC_BITS        = 64;
    localparam int FRAC_SHIFT      = 48;
    localparam int COORD_BITS_DEF  = 32;

    localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};

    // Signed add that clamps to the 64-bit range.
    function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                    input logic [ACC_BITS-1:0] b);
        logic [ACC_BITS-1:0] r;
        r = a + b;
        if (a[ACC_BITS-1] == b[ACC_BITS-1] && r[ACC_BITS-1] != a[ACC_BITS-1])
        begin
            r = a[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
        end
        return r;
    endfunction

    // Turns an unsigned quotient and the sign of the difference into a clamped term.
    function automatic logic [ACC_BITS-1:0] signed_term(input logic [ACC_BITS-1:0] q,
                                                        input logic ovf,
                                                        input logic neg);
        logic [ACC_BITS-1:0] t;
        if (ovf || (q[ACC_BITS-1] && (|q[ACC_BITS-2:0])))
        begin
            t = neg ? ACC_MIN : ACC_MAX;
        end
        else if (!neg)
        begin
            t = (q == ACC_MIN) ? ACC_MAX : q;
        end
        else
        begin
            t = ACC_BITS'(0) - q;
        end
        return t;
    endfunction

endpackage

### rtl/gpa_pair_if.sv
// Input channel of the accumulator: one body pair per item.
// Depends on gpa_pkg for the field widths.
interface gpa_pair_if;
    import gpa_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_BITS-1:0]  target_x;
    logic signed [FIELD_BITS-1:0]  target_y;
    logic signed [FIELD_BITS-1:0]  target_z;
    logic signed [FIELD_BITS-1:0]  source_x;
    logic signed [FIELD_BITS-1:0]  source_y;
    logic signed [FIELD_BITS-1:0]  source_z;
    logic        [MASS_BITS-1:0]   source_mass;
    logic                          first_pair;
    logic                          last_pair;

    modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                    source_z, source_mass, first_pair, last_pair, input ready);
    modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, source_mass, first_pair, last_pair, output ready);
endinterface

### rtl/gpa_accel_if.sv
// Output channel of the accumulator: one summed acceleration per item.
// Depends on gpa_pkg for the accumulator width.
interface gpa_accel_if;
    import gpa_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [ACC_BITS-1:0]  accel_x;
    logic signed [ACC_BITS-1:0]  accel_y;
    logic signed [ACC_BITS-1:0]  accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

### rtl/gpa_mul.sv
// Bit-serial shift-add multiplier: one bit of b per cycle.
// Standalone; no package use.
module gpa_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= {{BW{1'b0}}, a};
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

### rtl/gpa_sqrt.sv
// Digit-by-digit integer square root: two radicand bits per cycle.
// Standalone; SW must be even.
module gpa_sqrt #(
    parameter int SW = 66
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SW-1:0]   radicand,
    output logic            done,
    output logic [SW/2-1:0] root
);
    localparam int RW = SW / 2;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] s_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] rem_reg;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    assign rem_sh = {rem_reg[RW-1:0], s_reg[SW-1:SW-2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            s_reg <= {s_reg[SW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

### rtl/gpa_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Keeps the low 64 quotient bits and a flag for any higher bit set.
module gpa_div #(
    parameter int NW = 113,
    parameter int DW = 99
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [63:0]   quot,
    output logic          ovf
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [63:0]   q_reg;
    logic          ovf_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          fits;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign fits   = !diff[DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
            q_reg   <= {q_reg[62:0], fits};
            ovf_reg <= ovf_reg | q_reg[63];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;
endmodule

### rtl/gravity_pair_accel_accumulator_core.sv
// A pair with coincident points ends after the squares. One pair is worked at a time and
// the next is taken once the sequencer is back in idle; the bit-serial divider, run once
// per axis over the full numerator width, is the longest step. A result item still waiting
// at the output holds the end of the next group's last pair until it is taken.
// Reset (rst_n, asynchronous, active low) clears the sums, the sequencer and the output.
module gravity_pair_accel_accumulator_core
    import gpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    gpa_pair_if.sink    pair,
    gpa_accel_if.source result
);
    localparam int DBW = COORD_BITS + 1;
    localparam int SBW = 2 * DBW;
    localparam int RBW = DBW;
    localparam int DNW = SBW + RBW;
    localparam int PMW = DBW + MASS_BITS;
    localparam int NMW = PMW + FRAC_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_GO, ST_SQ_WAIT, ST_RT_GO, ST_RT_WAIT, ST_DN_GO, ST_DN_WAIT,
        ST_NM_GO, ST_NM_WAIT, ST_DV_GO, ST_DV_WAIT, ST_FIN
    } state_t;

    state_t               state_reg;
    logic [1:0]           axis_reg;
    logic [DBW-1:0]       mag_reg [3];
    logic [2:0]           neg_reg;
    logic [MASS_BITS-1:0] mass_reg;
    logic                 last_reg;
    logic [SBW-1:0]       s_reg;
    logic [ACC_BITS-1:0]  sum_reg [3];
    logic                 res_valid_reg;
    logic [ACC_BITS-1:0]  res_reg [3];

    logic [FIELD_BITS-1:0] tf [3];
    logic [FIELD_BITS-1:0] sf [3];
    logic [COORD_BITS-1:0] tc [3];
    logic [COORD_BITS-1:0] sc [3];
    logic [DBW-1:0]        d [3];
    logic [DBW-1:0]        mag [3];

    logic           sq_done, rt_done, dn_done, nm_done, dv_done, dv_ovf;
    logic [SBW-1:0] sq_prod;
    logic [RBW-1:0] rt_root;
    logic [DNW-1:0] dn_prod;
    logic [PMW-1:0] nm_prod;
    logic [63:0]    dv_quot;
    logic [SBW-1:0] s_next;
    logic [ACC_BITS-1:0] term;
    logic           accept;
    logic           res_load;

    assign tf[0] = pair.target_x;
    assign tf[1] = pair.target_y;
    assign tf[2] = pair.target_z;
    assign sf[0] = pair.source_x;
    assign sf[1] = pair.source_y;
    assign sf[2] = pair.source_z;

    // Coordinates are the low COORD_BITS bits of the field; above the field they are zero.
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        for (genvar i = 0; i < COORD_BITS; i++)
        begin : g_bit
            if (i < FIELD_BITS)
            begin : g_in
                assign tc[k][i] = tf[k][i];
                assign sc[k][i] = sf[k][i];
            end
            else
            begin : g_out
                assign tc[k][i] = 1'b0;
                assign sc[k][i] = 1'b0;
            end
        end
        assign d[k]   = {sc[k][COORD_BITS-1], sc[k]} - {tc[k][COORD_BITS-1], tc[k]};
        assign mag[k] = d[k][DBW-1] ? (DBW'(0) - d[k]) : d[k];
    end

    assign accept       = pair.valid && pair.ready;
    assign pair.ready   = (state_reg == ST_IDLE);
    assign s_next       = s_reg + sq_prod;
    assign term         = signed_term(dv_quot, dv_ovf, neg_reg[axis_reg]);
    assign res_load     = (state_reg == ST_FIN) && last_reg && (!res_valid_reg || result.ready);

    gpa_mul #(.AW(DBW), .BW(DBW)) u_sq_mul (
        .clk, .rst_n, .start(state_reg == ST_SQ_GO), .a(mag_reg[axis_reg]),
        .b(mag_reg[axis_reg]), .done(sq_done), .prod(sq_prod)
    );

    gpa_sqrt #(.SW(SBW)) u_sqrt (
        .clk, .rst_n, .start(state_reg == ST_RT_GO), .radicand(s_reg),
        .done(rt_done), .root(rt_root)
    );

    gpa_mul #(.AW(SBW), .BW(RBW)) u_den_mul (
        .clk, .rst_n, .start(state_reg == ST_DN_GO), .a(s_reg), .b(rt_root),
        .done(dn_done), .prod(dn_prod)
    );

    gpa_mul #(.AW(DBW), .BW(MASS_BITS)) u_num_mul (
        .clk, .rst_n, .start(state_reg == ST_NM_GO), .a(mag_reg[axis_reg]), .b(mass_reg),
        .done(nm_done), .prod(nm_prod)
    );

    gpa_div #(.NW(NMW), .DW(DNW)) u_div (
        .clk, .rst_n, .start(state_reg == ST_DV_GO), .num({nm_prod, {FRAC_SHIFT{1'b0}}}),
        .den(dn_prod), .done(dv_done), .quot(dv_quot), .ovf(dv_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            neg_reg       <= '0;
            mass_reg      <= '0;
            last_reg      <= 1'b0;
            s_reg         <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= '0;
                sum_reg[k] <= '0;
                res_reg[k] <= '0;
            end
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag[k];
                            neg_reg[k] <= d[k][DBW-1];
                            if (pair.first_pair)
                            begin
                                sum_reg[k] <= '0;
                            end
                        end
                        mass_reg  <= pair.source_mass;
                        last_reg  <= pair.last_pair;
                        s_reg     <= '0;
                        axis_reg  <= '0;
                        state_reg <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO:   state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT:
                begin
                    if (sq_done)
                    begin
                        s_reg <= s_next;
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg  <= '0;
                            state_reg <= (s_next == '0) ? ST_FIN : ST_RT_GO;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_SQ_GO;
                        end
                    end
                end
                ST_RT_GO:   state_reg <= ST_RT_WAIT;
                ST_RT_WAIT: if (rt_done) state_reg <= ST_DN_GO;
                ST_DN_GO:   state_reg <= ST_DN_WAIT;
                ST_DN_WAIT: if (dn_done) state_reg <= ST_NM_GO;
                ST_NM_GO:   state_reg <= ST_NM_WAIT;
                ST_NM_WAIT: if (nm_done) state_reg <= ST_DV_GO;
                ST_DV_GO:   state_reg <= ST_DV_WAIT;
                ST_DV_WAIT:
                begin
                    if (dv_done)
                    begin
                        sum_reg[axis_reg] <= sat_add(sum_reg[axis_reg], term);
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_NM_GO;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (res_load)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            res_reg[k] <= sum_reg[k];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.accel_x = res_reg[0];
    assign result.accel_y = res_reg[1];
    assign result.accel_z = res_reg[2];
endmodule

### rtl/gpa_checker.sv
// Port-level checks for the accumulator core, attached by the bind below.
// Depends only on the top level's port signals.
module gpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_x
);
    // A result that is not taken stays valid and keeps its x value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x))
        else $error("result changed while stalled");

    // After taking a pair the block is busy with it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pair accepted while the previous one is still in work");

    // A new result appears only at the end of a pair's work.
    a_res_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without a pair in work");
endmodule

bind gravity_pair_accel_accumulator_core gpa_checker u_gpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pair.valid),
    .in_ready  (pair.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.accel_x)
);

### tb/gravity_pair_accel_accumulator_core_tb.sv
// Testbench for gravity_pair_accel_accumulator_core: drives body pairs, predicts the
// summed accelerations with its own wide-integer model and checks every result item.
// Depends on gpa_pkg, gpa_pair_if, gpa_accel_if and the core itself.
module gravity_pair_accel_accumulator_core_tb;
    import gpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 700;
    localparam int CYCLE_LIMIT   = 2500000;
    localparam int QUIET_TAIL    = 80;

    typedef struct {
        logic signed [FIELD_BITS-1:0] tx, ty, tz;
        logic signed [FIELD_BITS-1:0] sx, sy, sz;
        logic [MASS_BITS-1:0]         mass;
        logic                         first_pair;
        logic                         last_pair;
    } body_pair_t;

    typedef struct {
        logic [ACC_BITS-1:0] ax, ay, az;
    } accel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gpa_pair_if  pair ();
    gpa_accel_if result ();

    gravity_pair_accel_accumulator_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result)
    );

    always #10 clk = ~clk;

    body_pair_t pending_pairs[$];
    accel_t     expected_accels[$];
    logic [ACC_BITS-1:0] accel_sum[3];
    int accepted_pairs = 0;
    int quiet_from = 1 << 30;
    int mismatches = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int cycles = 0;
    body_pair_t cur_pair;

    function automatic logic [ACC_BITS-1:0] clamp_add(input logic [ACC_BITS-1:0] a,
                                                      input logic [ACC_BITS-1:0] b);
        logic [ACC_BITS-1:0] r;
        r = a + b;
        if (a[ACC_BITS-1] == b[ACC_BITS-1] && r[ACC_BITS-1] != a[ACC_BITS-1])
        begin
            r = a[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
        end
        return r;
    endfunction

    // Adds one pair to the running sums and queues the sums when the group ends.
    task automatic accumulate_pair(input body_pair_t p);
        logic signed [FIELD_BITS:0] d[3];
        logic [FIELD_BITS:0]        mag[3];
        logic [191:0] s, den, num, q, cand;
        logic [63:0]  root;
        logic [ACC_BITS-1:0] term;
        accel_t e;
        d[0] = {p.sx[FIELD_BITS-1], p.sx} - {p.tx[FIELD_BITS-1], p.tx};
        d[1] = {p.sy[FIELD_BITS-1], p.sy} - {p.ty[FIELD_BITS-1], p.ty};
        d[2] = {p.sz[FIELD_BITS-1], p.sz} - {p.tz[FIELD_BITS-1], p.tz};
        if (p.first_pair)
        begin
            accel_sum[0] = '0;
            accel_sum[1] = '0;
            accel_sum[2] = '0;
        end
        s = '0;
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = d[a][FIELD_BITS] ? -d[a] : d[a];
            s = s + 192'(mag[a]) * 192'(mag[a]);
        end
        // Coincident points leave the sums untouched.
        if (s != 0)
        begin
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = 192'(root | (64'd1 << b));
                if (cand * cand <= s)
                    root = root | (64'd1 << b);
            end
            den = s * 192'(root);
            for (int a = 0; a < 3; a++)
            begin
                num = (192'(mag[a]) * 192'(p.mass)) << FRAC_SHIFT;
                q = num / den;
                if (q > 192'(ACC_MIN))
                    term = d[a][FIELD_BITS] ? ACC_MIN : ACC_MAX;
                else if (!d[a][FIELD_BITS])
                    term = (q == 192'(ACC_MIN)) ? ACC_MAX : q[ACC_BITS-1:0];
                else
                    term = -q[ACC_BITS-1:0];
                accel_sum[a] = clamp_add(accel_sum[a], term);
            end
        end
        if (p.last_pair)
        begin
            e.ax = accel_sum[0];
            e.ay = accel_sum[1];
            e.az = accel_sum[2];
            expected_accels.push_back(e);
        end
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] base);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return base + $urandom_range(0, 2 * 65536) - 65536;
            2: return base + $urandom_range(0, 1 << 24) - (1 << 23);
            default: return $signed(20'($urandom));
        endcase
    endfunction

    task automatic push_pair(input logic [31:0] tx, ty, tz, sx, sy, sz, mass,
                             input logic fp, lp);
        body_pair_t p;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.mass = mass;
        p.first_pair = fp;
        p.last_pair = lp;
        pending_pairs.push_back(p);
    endtask

    task automatic wait_drained();
        wait (pending_pairs.size() == 0 && !pair.valid && expected_accels.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: the valid stays up until the item is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (pair.valid && pair.ready)
            begin
                accumulate_pair(cur_pair);
                accepted_pairs++;
                if (accepted_pairs < quiet_from && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            if (!pair.valid || pair.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pair.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    cur_pair = pending_pairs.pop_front();
                    pair.target_x    <= cur_pair.tx;
                    pair.target_y    <= cur_pair.ty;
                    pair.target_z    <= cur_pair.tz;
                    pair.source_x    <= cur_pair.sx;
                    pair.source_y    <= cur_pair.sy;
                    pair.source_z    <= cur_pair.sz;
                    pair.source_mass <= cur_pair.mass;
                    pair.first_pair  <= cur_pair.first_pair;
                    pair.last_pair   <= cur_pair.last_pair;
                    pair.valid       <= 1'b1;
                end
                else
                begin
                    pair.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result item and stalls in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_accels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %h %h %h",
                                 result.accel_x, result.accel_y, result.accel_z);
                end
                else
                begin
                    accel_t e;
                    e = expected_accels.pop_front();
                    if (result.accel_x !== e.ax || result.accel_y !== e.ay ||
                        result.accel_z !== e.az)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("accel mismatch: expected %h %h %h, got %h %h %h",
                                     e.ax, e.ay, e.az,
                                     result.accel_x, result.accel_y, result.accel_z);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                result.ready <= 1'b0;
            end
            else if (accepted_pairs < quiet_from && $urandom_range(0, 3) == 0)
            begin
                recv_stall = $urandom_range(0, 4);
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] bx, by, bz;
        int group_len;
        int items;
        bit noise;
        pair.valid = 1'b0;
        pair.target_x = '0; pair.target_y = '0; pair.target_z = '0;
        pair.source_x = '0; pair.source_y = '0; pair.source_z = '0;
        pair.source_mass = '0;
        pair.first_pair = 1'b0;
        pair.last_pair = 1'b0;
        result.ready = 1'b0;
        accel_sum[0] = '0; accel_sum[1] = '0; accel_sum[2] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, self pairs, zero and full mass, flag combinations.
        push_pair(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1);
        push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1);
        push_pair(32'h7FFF_FFFF, 32'h8000_0000, 0,
                  32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0);
        push_pair(0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 0, 0);
        push_pair(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 1);
        push_pair(0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF, 0, 1);
        push_pair(5, 6, 7, 5, 6, 7, 32'h0001_0000, 1, 1);
        push_pair(0, 0, 0, 32'h0001_0000, 0, 0, 0, 1, 1);
        push_pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000, 1, 0);
        push_pair(0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'h0001_0000, 0, 1);
        push_pair(0, 0, 0, 32'h0000_0100, 0, 0, 32'h8000_0000, 1, 0);
        push_pair(0, 0, 0, 32'h0000_0100, 0, 0, 32'h8000_0000, 0, 1);
        push_pair(0, 0, 0, 32'hFFFF_FF00, 0, 0, 32'h8000_0000, 0, 0);
        push_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                  32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 0, 1);
        push_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h5A5A_A5A5, 1, 1);
        // The random pairs are queued only after all of the directed results are in.
        wait_drained();

        items = 0;
        while (items < 850)
        begin
            noise = ($urandom_range(0, 9) == 0);
            group_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
            bx = pick_coord(0); by = pick_coord(0); bz = pick_coord(0);
            for (int i = 0; i < group_len; i++)
            begin
                logic [31:0] m;
                m = ($urandom_range(0, 9) == 0) ? 32'd0 :
                    ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF));
                if ($urandom_range(0, 9) == 0)
                    push_pair(bx, by, bz, bx, by, bz, m,
                              noise ? $urandom_range(0, 1) : (i == 0),
                              noise ? $urandom_range(0, 1) : (i == group_len - 1));
                else
                    push_pair(bx, by, bz, pick_coord(bx), pick_coord(by), pick_coord(bz), m,
                              noise ? $urandom_range(0, 1) : (i == 0),
                              noise ? $urandom_range(0, 1) : (i == group_len - 1));
                items++;
            end
        end
        quiet_from = accepted_pairs + pending_pairs.size() - QUIET_TAIL;
        wait_drained();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### sim.f
rtl/gpa_pkg.sv
rtl/gpa_pair_if.sv
rtl/gpa_accel_if.sv
rtl/gpa_mul.sv
rtl/gpa_sqrt.sv
rtl/gpa_div.sv
rtl/gravity_pair_accel_accumulator_core.sv
rtl/gpa_checker.sv
tb/gravity_pair_accel_accumulator_core_tb.sv
